// File: design/bba_pkg.sv
// Shared types and constants for the block bitmap allocator.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 4096;
  localparam int unsigned WORD_BITS_DEF  = 32;

  localparam int unsigned BLK_W      = 12;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned TOTAL_W    = 13;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(4096);
  localparam logic               REG_TOTAL   = 1'b0;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DOUBLE = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_FREE_EVAL,
    S_FINISH
  } ctrl_state_t;

  typedef enum logic [1:0] {
    RD_CUR,
    RD_ZERO,
    RD_NEXT,
    RD_QIDX
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_ZERO,
    WR_SET,
    WR_CLR
  } wr_kind_t;

  typedef enum logic [2:0] {
    RES_GRANT,
    RES_FULL,
    RES_DOUBLE,
    RES_RANGE,
    RES_FREED
  } res_src_t;

  typedef struct packed {
    logic     in_take;
    logic     clr_step;
    logic     scan_init;
    logic     scan_step;
    logic     load_q;
    rd_sel_t  rd_sel;
    logic     wr_en;
    wr_kind_t wr_kind;
    logic     res_load;
    res_src_t res_src;
    logic     out_load;
  } bba_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic op_free;
    logic in_range;
    logic hit;
    logic scan_last;
    logic bit_used;
    logic out_free;
  } bba_stat_t;

endpackage

`default_nettype wire

// File: design/bba_ctrl.sv
// Controller state machine of the block bitmap allocator.
// Depends on bba_pkg; drives the datapath through bba_cmd_t, reads bba_stat_t.
`timescale 1ns / 1ps
`default_nettype none

module bba_ctrl
  import bba_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  bba_stat_t  stat,
  output bba_cmd_t   cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (!stat.op_free) begin
          state_next = S_SCAN;
        end else if (!stat.in_range) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_FREE_EVAL;
        end
      end
      S_SCAN: begin
        if (stat.hit || stat.scan_last) state_next = S_FINISH;
      end
      S_FREE_EVAL: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.rd_sel  = RD_CUR;
    cmd.wr_kind = WR_ZERO;
    cmd.res_src = RES_FULL;
    s_tready = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        cmd.wr_en    = 1'b1;
        cmd.wr_kind  = WR_ZERO;
      end
      S_IDLE: begin
        s_tready    = 1'b1;
        cmd.in_take = s_tvalid;
      end
      S_DISPATCH: begin
        if (!stat.op_free) begin
          cmd.scan_init = 1'b1;
          cmd.rd_sel    = RD_ZERO;
        end else if (!stat.in_range) begin
          cmd.res_load = 1'b1;
          cmd.res_src  = RES_RANGE;
        end else begin
          cmd.load_q = 1'b1;
          cmd.rd_sel = RD_QIDX;
        end
      end
      S_SCAN: begin
        cmd.rd_sel = RD_NEXT;
        if (stat.hit) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_kind  = WR_SET;
          cmd.res_load = 1'b1;
          cmd.res_src  = RES_GRANT;
        end else if (stat.scan_last) begin
          cmd.res_load = 1'b1;
          cmd.res_src  = RES_FULL;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_FREE_EVAL: begin
        cmd.res_load = 1'b1;
        if (stat.bit_used) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_kind = WR_CLR;
          cmd.res_src = RES_FREED;
        end else begin
          cmd.res_src = RES_DOUBLE;
        end
      end
      S_FINISH: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        cmd.rd_sel = RD_CUR;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    (state != S_CLEAR) |=> (state != S_CLEAR))
    else $error("controller returned to the clearing pass");
`endif

endmodule

`default_nettype wire

// File: design/bba_dp.sv
// Datapath of the block bitmap allocator: bitmap memory, scan pointer,
// word-index reciprocal, result and output registers. Depends on bba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bba_dp
  import bba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int unsigned WORD_BITS  = WORD_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  bba_cmd_t               cmd,
  output bba_stat_t              stat,
  input  wire                    in_op,
  input  wire  [BLK_W-1:0]       in_blk,
  input  wire  [TOTAL_W-1:0]     total_blocks,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [BLK_W-1:0]       out_block,
  output logic [STAT_W-1:0]      out_status
);

  localparam int unsigned DEPTH = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int unsigned MW    = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CW    = (MW > TOTAL_W) ? MW : TOTAL_W;
  localparam int unsigned SH    = BLK_W + LW;
  localparam int unsigned RECIP = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned RW    = BLK_W + 2;
  localparam int unsigned PW    = BLK_W + RW + AW;
  localparam int unsigned XW    = BLK_W + AW;

  localparam logic [CW-1:0] MAX_C  = CW'(MAX_BLOCKS);
  localparam logic [CW:0]   WB_C   = (CW + 1)'(WORD_BITS);
  localparam logic [AW-1:0] LAST_W = AW'(DEPTH - 1);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] wr_data;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;

  logic                 op_reg;
  logic [BLK_W-1:0]     blk_reg;
  logic [AW-1:0]        wptr;
  logic [CW-1:0]        base;
  logic [AW-1:0]        clr_ptr;
  logic [BLK_W-1:0]     res_block;
  logic [STAT_W-1:0]    res_status;

  logic [CW-1:0]        count;
  logic [CW-1:0]        lim;
  logic [CW:0]          base_end;
  logic [WORD_BITS-1:0] valid_mask;
  logic [WORD_BITS-1:0] free_vec;
  logic [LW-1:0]        idx;
  logic [PW-1:0]        prod;
  logic [PW-1:0]        q_full;
  logic [AW-1:0]        q_idx;
  logic [XW-1:0]        word_base;
  logic [XW-1:0]        rem_full;
  logic [LW-1:0]        rbit;
  logic                 out_free;

  // effective block count
  always_comb begin
    count = (CW'(total_blocks) > MAX_C) ? MAX_C : CW'(total_blocks);
    lim   = (count > base) ? (count - base) : '0;
    base_end = {1'b0, base} + WB_C;
  end

  // word index and bit offset of the block being freed
  always_comb begin
    prod      = PW'(blk_reg) * PW'(RECIP);
    q_full    = prod >> SH;
    q_idx     = q_full[AW-1:0];
    word_base = XW'(wptr) * XW'(WORD_BITS);
    rem_full  = XW'(blk_reg) - word_base;
    rbit      = rem_full[LW-1:0];
  end

  // lowest free block in the current word
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      valid_mask[i] = (CW'(i) < lim);
    end
    free_vec = ~rdata & valid_mask;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_vec[i]) idx = LW'(i);
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_ZERO: rd_addr = '0;
      RD_NEXT: rd_addr = wptr + AW'(1);
      RD_QIDX: rd_addr = q_idx;
      default: rd_addr = wptr;
    endcase
    wr_addr = (cmd.wr_kind == WR_ZERO) ? clr_ptr : wptr;
    case (cmd.wr_kind)
      WR_SET:  wr_data = rdata | (WORD_BITS'(1) << idx);
      WR_CLR:  wr_data = rdata & ~(WORD_BITS'(1) << rbit);
      default: wr_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (cmd.clr_step) begin
      clr_ptr <= clr_ptr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      op_reg  <= in_op;
      blk_reg <= in_blk;
    end
    if (cmd.scan_init) begin
      wptr <= '0;
      base <= '0;
    end else if (cmd.scan_step) begin
      wptr <= wptr + AW'(1);
      base <= base_end[CW-1:0];
    end else if (cmd.load_q) begin
      wptr <= q_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_src)
        RES_GRANT: begin
          res_block  <= BLK_W'(base + CW'(idx));
          res_status <= STAT_OK;
        end
        RES_FREED: begin
          res_block  <= '0;
          res_status <= STAT_OK;
        end
        RES_DOUBLE: begin
          res_block  <= '0;
          res_status <= STAT_DOUBLE;
        end
        RES_RANGE: begin
          res_block  <= '0;
          res_status <= STAT_RANGE;
        end
        default: begin
          res_block  <= '0;
          res_status <= STAT_FULL;
        end
      endcase
    end
  end

  // output register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_block  <= res_block;
      out_status <= res_status;
    end
  end

  always_comb begin
    stat.clr_last  = (clr_ptr == LAST_W);
    stat.op_free   = (op_reg == OP_FREE);
    stat.in_range  = (CW'(blk_reg) < count);
    stat.hit       = |free_vec;
    stat.scan_last = (base_end >= {1'b0, count});
    stat.bit_used  = rdata[rbit];
    stat.out_free  = out_free;
  end

`ifndef SYNTHESIS
  a_set_one: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_en && cmd.wr_kind == WR_SET) |->
      ($countones(wr_data) == $countones(rdata) + 1))
    else $error("allocation did not set exactly one free bit");

  a_clr_one: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_en && cmd.wr_kind == WR_CLR) |->
      ($countones(wr_data) + 1 == $countones(rdata)))
    else $error("free did not clear exactly one used bit");

  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != STAT_OK && out_status != STAT_FULL) |->
      (out_block == '0))
    else $error("non-allocation result carries a block number");
`endif

endmodule

`default_nettype wire

// File: design/block_bitmap_allocator_unit.sv
// Block bitmap allocator: an allocate passes through the dispatch, scan and finish states,
// and the scan reads one bitmap word per cycle until it finds a free bit or the last word
// (DEPTH = MAX_BLOCKS/WORD_BITS rounded up, 128 at defaults), so its result waits on the scan.
// A free passes through the dispatch, free-evaluation and finish states (dispatch and finish when out of range).
// One request in work at a time; a result held by m_tready low stalls the next one.
// Reset: clearing pass over all DEPTH words with tready low; total_blocks 4096. Uses bba_pkg/ctrl/dp.
`timescale 1ns / 1ps
`default_nettype none

module block_bitmap_allocator_unit
  import bba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int unsigned WORD_BITS  = WORD_BITS_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  // slave stream
  input  wire                   s_tvalid,
  output logic                  s_tready,
  input  wire  [IN_DATA_W-1:0]  s_tdata,   // [11:0] block_number, [15:12] zero
  input  wire                   s_tuser,   // [0] operation
  // master stream
  output logic                  m_tvalid,
  input  wire                   m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [11:0] granted_block, [13:12] status
  // configuration
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  [PADDR_W-1:0]    paddr,
  input  wire  [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready
);

  bba_cmd_t          cmd;
  bba_stat_t         stat;
  logic [TOTAL_W-1:0] total_blocks;
  logic [BLK_W-1:0]   out_block;
  logic [STAT_W-1:0]  out_status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_blocks <= TOTAL_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TOTAL) begin
      total_blocks <= pwdata[TOTAL_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_TOTAL) ? PDATA_W'(total_blocks) : '0;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_op        (s_tuser),
    .in_blk       (s_tdata[BLK_W-1:0]),
    .total_blocks (total_blocks),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_block    (out_block),
    .out_status   (out_status)
  );

  assign m_tdata = {(OUT_DATA_W - BLK_W - STAT_W)'(0), out_status, out_block};

endmodule

`default_nettype wire
